// ===== sv/avc_nal_fu_a_packetizer_defines.svh =====
// Assertion macros for the FU-A packetizer.
// Taken in by the top level; relies on clk and arst_n in the including scope.
`ifndef AVC_NAL_FU_A_PACKETIZER_DEFINES_SVH
`define AVC_NAL_FU_A_PACKETIZER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AVCFU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define AVCFU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/avcfu_pkg.sv =====
// Shared types and constants of the FU-A packetizer.
// Used by the parser, the output buffer and the top level; no dependencies.
`default_nettype none

package avcfu_pkg;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_LEN_PREFIX = 2'd0;
	localparam logic [1:0] REG_MAX_PACKET = 2'd1;
	localparam logic [1:0] REG_HEADER     = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [2:0]  RST_LEN_PREFIX = 3'd0;
	localparam logic [13:0] RST_MAX_PACKET = 14'd1500;
	localparam logic [5:0]  RST_HEADER     = 6'd28;

	// NAL header constants; the FU indicator carries type 28.
	localparam logic [4:0] FU_IND_TYPE = 5'd28;
	localparam logic [4:0] VCL_FIRST   = 5'd1;
	localparam logic [4:0] VCL_LAST    = 5'd5;

	// Configuration register set.
	typedef struct packed {
		logic [2:0]  length_prefix_bytes;
		logic [13:0] max_packet_bytes;
		logic [5:0]  header_bytes;
	} cfg_t;

	// One output word before it reaches the stream port.
	typedef struct packed {
		logic [7:0]  out_byte;
		logic        packet_start;
		logic        packet_end;
		logic [13:0] payload_length;
		logic        marker_bit;
	} result_t;

	// The up to three words one input byte produces, slot 0 first.
	typedef result_t [2:0] result_run_t;

endpackage

`default_nettype wire

// ===== sv/avcfu_parse.sv =====
// Length-prefix parser and FU-A fragmenter state for the packetizer.
// Computes the words of one input byte combinationally; uses avcfu_pkg.
`default_nettype none

module avcfu_parse (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire avcfu_pkg::cfg_t      cfg,
	input  wire logic                 in_accept,
	input  wire logic [7:0]           data_byte,
	input  wire logic                 unit_first,
	input  wire logic [23:0]          unit_length,
	output avcfu_pkg::result_run_t    results,
	output logic [1:0]                result_count
);

	// State registers.
	logic [23:0] unit_left_q, unit_left_d;
	logic        in_prefix_q, in_prefix_d;
	logic [31:0] acc_q, acc_d;
	logic [2:0]  seen_q, seen_d;
	logic [23:0] nal_size_q, nal_size_d;
	logic [23:0] nal_off_q, nal_off_d;
	logic [13:0] frag_left_q, frag_left_d;
	logic        frag_mode_q, frag_mode_d;
	logic [6:0]  hdr_fields_q, hdr_fields_d;
	logic        drop_q, drop_d;

	// Working values of the step.
	logic [23:0] e_left, e_off, avail, size_new, rest, after, dl_h, dl_d;
	logic        e_prefix, e_drop, is_final, vcl, need_hdr, fu_end, mk_h, mk_d;
	logic [31:0] e_acc, acc_sh;
	logic [2:0]  e_seen, seen_inc;
	logic [13:0] e_frag, room, frag_size, frag_cur;
	logic [15:0] room_raw;
	logic [6:0]  fields;
	logic [24:0] off_inc;

	// Payload room of one fragment, at least one byte.
	always_comb begin
		room_raw = {2'b00, cfg.max_packet_bytes} - {10'd0, cfg.header_bytes} - 16'd2;
		if (room_raw[15] || room_raw == 16'd0) begin
			room = 14'd1;
		end else begin
			room = room_raw[13:0];
		end
	end

	// One byte step: next state and the words it produces.
	always_comb begin
		// A new access unit restarts parsing.
		e_left   = unit_first ? unit_length : unit_left_q;
		e_prefix = unit_first ? 1'b1 : in_prefix_q;
		e_acc    = unit_first ? 32'd0 : acc_q;
		e_seen   = unit_first ? 3'd0 : seen_q;
		e_off    = unit_first ? 24'd0 : nal_off_q;
		e_frag   = unit_first ? 14'd0 : frag_left_q;
		e_drop   = unit_first ? 1'b0 : drop_q;

		unit_left_d  = e_left;
		in_prefix_d  = e_prefix;
		acc_d        = e_acc;
		seen_d       = e_seen;
		nal_size_d   = nal_size_q;
		nal_off_d    = e_off;
		frag_left_d  = e_frag;
		frag_mode_d  = frag_mode_q;
		hdr_fields_d = hdr_fields_q;
		drop_d       = e_drop;

		results      = '0;
		result_count = 2'd0;

		acc_sh   = {e_acc[23:0], data_byte};
		seen_inc = e_seen + 3'd1;
		avail    = e_left - 24'd1;
		size_new = (acc_sh < {8'd0, avail}) ? acc_sh[23:0] : avail;

		// Does the current NAL end the unit?
		rest     = nal_size_q - e_off;
		after    = (e_left >= rest) ? (e_left - rest) : 24'd0;
		is_final = after <= {21'd0, cfg.length_prefix_bytes};

		fields   = (e_off == 24'd0) ? data_byte[6:0] : hdr_fields_q;
		vcl      = (fields[4:0] >= avcfu_pkg::VCL_FIRST) &&
			(fields[4:0] <= avcfu_pkg::VCL_LAST);

		// Fragment bookkeeping.
		need_hdr  = (e_off == 24'd0) || (e_frag == 14'd0);
		dl_h      = (e_off == 24'd0) ? (nal_size_q - 24'd1) : (nal_size_q - e_off);
		dl_d      = nal_size_q - e_off;
		frag_size = (dl_h < {10'd0, room}) ? dl_h[13:0] : room;
		fu_end    = dl_h <= {10'd0, room};
		frag_cur  = need_hdr ? frag_size : e_frag;
		mk_h      = fu_end && is_final && vcl;
		mk_d      = ({10'd0, frag_cur} == dl_d) && is_final && vcl;
		off_inc   = {1'b0, e_off} + 25'd1;

		if (e_left != 24'd0) begin
			unit_left_d = avail;
			if (!e_drop) begin
				if (e_prefix) begin
					// Length prefix byte.
					if (e_seen == 3'd0 && (cfg.length_prefix_bytes == 3'd0 ||
					    e_left <= {21'd0, cfg.length_prefix_bytes})) begin
						drop_d = 1'b1;
					end else begin
						acc_d  = acc_sh;
						seen_d = seen_inc;
						if (seen_inc == cfg.length_prefix_bytes) begin
							if (acc_sh == 32'd0) begin
								drop_d = 1'b1;
							end else begin
								nal_size_d  = size_new;
								nal_off_d   = 24'd0;
								frag_left_d = 14'd0;
								frag_mode_d = (size_new >= 24'd2) &&
									(({1'b0, size_new} + {19'd0, cfg.header_bytes}) >
									 {11'd0, cfg.max_packet_bytes});
								in_prefix_d = 1'b0;
								acc_d       = 32'd0;
								seen_d      = 3'd0;
							end
						end
					end
				end else begin
					if (e_off == 24'd0) begin
						hdr_fields_d = fields;
					end
					if (!frag_mode_q) begin
						// Single NAL packet: pass the byte through.
						results[0].out_byte       = data_byte;
						results[0].packet_start   = (e_off == 24'd0);
						results[0].packet_end     = (off_inc == {1'b0, nal_size_q});
						results[0].payload_length = (e_off == 24'd0) ?
							nal_size_q[13:0] : 14'd0;
						results[0].marker_bit     = is_final && vcl;
						result_count = 2'd1;
					end else begin
						// FU-A: indicator and header at each fragment start.
						if (need_hdr) begin
							results[0].out_byte       = {1'b0, fields[6:5],
								avcfu_pkg::FU_IND_TYPE};
							results[0].packet_start   = 1'b1;
							results[0].payload_length = frag_size + 14'd2;
							results[0].marker_bit     = mk_h;
							results[1].out_byte       = {(e_off == 24'd0), fu_end,
								1'b0, fields[4:0]};
							results[1].marker_bit     = mk_h;
							result_count = 2'd2;
						end
						frag_left_d = frag_cur;
						if (e_off != 24'd0) begin
							if (need_hdr) begin
								results[2].out_byte   = data_byte;
								results[2].packet_end = (frag_cur == 14'd1);
								results[2].marker_bit = mk_d;
								result_count = 2'd3;
							end else begin
								results[0].out_byte   = data_byte;
								results[0].packet_end = (frag_cur == 14'd1);
								results[0].marker_bit = mk_d;
								result_count = 2'd1;
							end
							frag_left_d = frag_cur - 14'd1;
						end
					end
					// Advance within the NAL; its end returns to prefix parsing.
					nal_off_d = off_inc[23:0];
					if (off_inc >= {1'b0, nal_size_q}) begin
						in_prefix_d = 1'b1;
						acc_d       = 32'd0;
						seen_d      = 3'd0;
						frag_left_d = 14'd0;
					end
				end
			end
		end
	end

	// State update on each accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_left_q  <= '0;
			in_prefix_q  <= 1'b1;
			acc_q        <= '0;
			seen_q       <= '0;
			nal_size_q   <= '0;
			nal_off_q    <= '0;
			frag_left_q  <= '0;
			frag_mode_q  <= 1'b0;
			hdr_fields_q <= '0;
			drop_q       <= 1'b0;
		end else if (in_accept) begin
			unit_left_q  <= unit_left_d;
			in_prefix_q  <= in_prefix_d;
			acc_q        <= acc_d;
			seen_q       <= seen_d;
			nal_size_q   <= nal_size_d;
			nal_off_q    <= nal_off_d;
			frag_left_q  <= frag_left_d;
			frag_mode_q  <= frag_mode_d;
			hdr_fields_q <= hdr_fields_d;
			drop_q       <= drop_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/avcfu_outbuf.sv =====
// Three-slot result register of the packetizer: holds the words of one byte
// and hands them out one per cycle while out_ready is high. Uses avcfu_pkg.
`default_nettype none

module avcfu_outbuf (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load,
	input  wire avcfu_pkg::result_run_t run,
	input  wire logic [1:0]            run_count,
	output logic                       can_load,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output avcfu_pkg::result_t         out_word,
	output logic                       out_last
);

	avcfu_pkg::result_run_t slot_q;
	logic [1:0]             cnt_q;
	logic                   take;

	assign out_valid = (cnt_q != 2'd0);
	assign take      = out_valid && out_ready;
	assign out_word  = slot_q[0];
	assign out_last  = (cnt_q == 2'd1);
	// A new run may enter once the current one is gone or leaves this cycle.
	assign can_load  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready);

	// Word count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= run_count;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Slots shift toward slot 0 as words are taken.
	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= run;
		end else if (take) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

endmodule

`default_nettype wire

// ===== sv/avc_nal_fu_a_packetizer.sv =====
// H.264 FU-A packetizer top level: configuration registers, parser, result buffer.
// The words of an accepted byte are registered in the result buffer before they are offered.
// Throughput: one byte per cycle while each byte gives at most one word and m_axis_tready
// is high; a byte that opens a fragment gives up to three words, and input waits for them.
// Reset: arst_n asynchronous, active low; clears parser state, word count and
// restores the configuration registers to their defaults.
`default_nettype none
`include "avc_nal_fu_a_packetizer_defines.svh"

module avc_nal_fu_a_packetizer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input byte stream.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // [7:0] data_byte, [31:8] unit_length
	input  wire logic [0:0]  s_axis_tuser,  // [0] unit_first
	// Output packet stream.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // [7:0] out_byte, [21:8] payload_length, rest 0
	output logic [2:0]       m_axis_tuser,  // [0] packet_start, [1] packet_end, [2] marker_bit
	output logic             m_axis_tlast,  // last_of_run
	// Configuration port.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	avcfu_pkg::cfg_t        cfg_q;
	avcfu_pkg::result_run_t run;
	avcfu_pkg::result_t     word;
	logic [1:0]             run_count;
	logic                   in_accept, can_load, cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.length_prefix_bytes <= avcfu_pkg::RST_LEN_PREFIX;
			cfg_q.max_packet_bytes    <= avcfu_pkg::RST_MAX_PACKET;
			cfg_q.header_bytes        <= avcfu_pkg::RST_HEADER;
		end else if (cfg_write) begin
			case (paddr[3:2])
				avcfu_pkg::REG_LEN_PREFIX: cfg_q.length_prefix_bytes <= pwdata[2:0];
				avcfu_pkg::REG_MAX_PACKET: cfg_q.max_packet_bytes    <= pwdata[13:0];
				avcfu_pkg::REG_HEADER:     cfg_q.header_bytes        <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (paddr[3:2])
			avcfu_pkg::REG_LEN_PREFIX: prdata = {29'd0, cfg_q.length_prefix_bytes};
			avcfu_pkg::REG_MAX_PACKET: prdata = {18'd0, cfg_q.max_packet_bytes};
			avcfu_pkg::REG_HEADER:     prdata = {26'd0, cfg_q.header_bytes};
			default:                   prdata = 32'd0;
		endcase
	end

	assign s_axis_tready = can_load;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	avcfu_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_accept    (in_accept),
		.data_byte    (s_axis_tdata[7:0]),
		.unit_first   (s_axis_tuser[0]),
		.unit_length  (s_axis_tdata[31:8]),
		.results      (run),
		.result_count (run_count)
	);

	avcfu_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_accept),
		.run       (run),
		.run_count (run_count),
		.can_load  (can_load),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_word  (word),
		.out_last  (m_axis_tlast)
	);

	// Pack the output word.
	assign m_axis_tdata = {2'b00, word.payload_length, word.out_byte};
	assign m_axis_tuser = {word.marker_bit, word.packet_end, word.packet_start};

	// A byte that produces words shows its first word in the next cycle.
	`AVCFU_ASSERT_NEXT(a_run_appears, in_accept && run_count != 2'd0, m_axis_tvalid,
		"accepted byte produced words but none are offered")
	// Input stalls while more than one word of a run is still pending.
	`AVCFU_ASSERT_NOW(a_stall_mid_run, m_axis_tvalid && !m_axis_tlast, !s_axis_tready,
		"input accepted while a run is still being delivered")
	// Every packet start carries a nonzero payload length.
	`AVCFU_ASSERT_NOW(a_start_length, m_axis_tvalid && m_axis_tuser[0],
		m_axis_tdata[21:8] != 14'd0, "packet start without payload length")

endmodule

`default_nettype wire
